[rtl/json_nesting_shape_checker_top_defines.svh]
// Assertion macros shared by the nesting shape checker.
`ifndef JSON_NESTING_SHAPE_CHECKER_TOP_DEFINES_SVH
`define JSON_NESTING_SHAPE_CHECKER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define JNSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define JNSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/jnsc_pkg.sv]
// Types and character codes shared by the nesting shape checker.
package jnsc_pkg;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic doc_valid;
        logic depth_overflow;
    } t_out_beat;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
        logic kind;
    } t_stk_ctl;

    typedef struct packed {
        logic depth_zero;
        logic depth_one;
        logic full;
        logic top_kind;
    } t_stk_sts;

endpackage

[rtl/jnsc_stack.sv]
// Opener kind stack: memory with the top entry and the one below it held in registers.
module jnsc_stack
    import jnsc_pkg::*;
#(
    parameter int MAX_DEPTH = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_stk_ctl i_ctl,
    output t_stk_sts o_sts
);

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int AW = $clog2(MAX_DEPTH);

    logic          r_mem [MAX_DEPTH];
    logic [DW-1:0] r_depth;
    logic [DW-1:0] n_depth;
    logic [DW-1:0] w_rd_ptr;
    logic          r_top;
    logic          r_below;

    always_comb begin
        n_depth = r_depth;
        if (i_ctl.clear) begin
            n_depth = '0;
        end else if (i_ctl.push) begin
            n_depth = r_depth + DW'(1);
        end else if (i_ctl.pop) begin
            n_depth = r_depth - DW'(1);
        end
        w_rd_ptr = n_depth - DW'(2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else begin
            r_depth <= n_depth;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_depth[AW-1:0]] <= i_ctl.kind;
        end
        if (n_depth >= DW'(2)) begin
            r_below <= r_mem[w_rd_ptr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_top <= i_ctl.kind;
        end else if (i_ctl.pop) begin
            r_top <= r_below;
        end
    end

    assign o_sts.depth_zero = (r_depth == '0);
    assign o_sts.depth_one  = (r_depth == DW'(1));
    assign o_sts.full       = (r_depth == DW'(MAX_DEPTH));
    assign o_sts.top_kind   = r_top;

endmodule

[rtl/jnsc_core.sv]
// Per-byte scanner: quote and escape tracking, shape rules and the end-of-document verdict.
module jnsc_core
    import jnsc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_beat  i_in,
    input  t_stk_sts  i_sts,
    output t_stk_ctl  o_ctl,
    output logic      o_res_valid,
    output t_out_beat o_res
);

    logic r_in_quotes;
    logic r_after_bs;
    logic r_root_seen;
    logic r_err;
    logic r_ovf;
    logic n_in_quotes;
    logic n_after_bs;
    logic n_root_seen;
    logic n_err;
    logic n_ovf;
    logic w_push;
    logic w_pop;
    logic w_depth_zero_next;
    logic [7:0] w_c;

    assign w_c = i_in.byte_in;

    always_comb begin
        n_in_quotes = r_in_quotes;
        n_after_bs  = r_after_bs;
        n_root_seen = r_root_seen;
        n_err       = r_err;
        n_ovf       = r_ovf;
        w_push      = 1'b0;
        w_pop       = 1'b0;
        if (!r_err) begin
            if (r_in_quotes) begin
                if (r_after_bs) begin
                    n_after_bs = 1'b0;
                end else if (w_c == CH_BSLASH) begin
                    n_after_bs = 1'b1;
                end else if (w_c == CH_QUOTE) begin
                    n_in_quotes = 1'b0;
                end
            end else if (w_c == CH_QUOTE) begin
                n_in_quotes = 1'b1;
            end else if (w_c == CH_LBRACE || w_c == CH_LBRACK) begin
                if (i_sts.depth_zero && (r_root_seen || w_c != CH_LBRACE)) begin
                    n_err = 1'b1;
                end else if (i_sts.full) begin
                    n_ovf = 1'b1;
                    n_err = 1'b1;
                end else begin
                    if (i_sts.depth_zero) begin
                        n_root_seen = 1'b1;
                    end
                    w_push = 1'b1;
                end
            end else if (w_c == CH_RBRACE || w_c == CH_RBRACK) begin
                if (i_sts.depth_zero || i_sts.top_kind != (w_c == CH_RBRACE)) begin
                    n_err = 1'b1;
                end else begin
                    w_pop = 1'b1;
                end
            end else if (i_sts.depth_zero && !(w_c inside {[CH_TAB:CH_CR], CH_SPACE})) begin
                n_err = 1'b1;
            end
        end
        w_depth_zero_next = (i_sts.depth_zero && !w_push) || (i_sts.depth_one && w_pop);
    end

    assign o_ctl.clear = i_fire && i_in.last_byte;
    assign o_ctl.push  = i_fire && w_push;
    assign o_ctl.pop   = i_fire && w_pop;
    assign o_ctl.kind  = (w_c == CH_LBRACE);

    assign o_res_valid          = i_fire && i_in.last_byte;
    assign o_res.doc_valid      = !n_err && n_root_seen && !n_in_quotes && w_depth_zero_next;
    assign o_res.depth_overflow = n_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_quotes <= 1'b0;
            r_after_bs  <= 1'b0;
            r_root_seen <= 1'b0;
            r_err       <= 1'b0;
            r_ovf       <= 1'b0;
        end else if (i_fire) begin
            if (i_in.last_byte) begin
                r_in_quotes <= 1'b0;
                r_after_bs  <= 1'b0;
                r_root_seen <= 1'b0;
                r_err       <= 1'b0;
                r_ovf       <= 1'b0;
            end else begin
                r_in_quotes <= n_in_quotes;
                r_after_bs  <= n_after_bs;
                r_root_seen <= n_root_seen;
                r_err       <= n_err;
                r_ovf       <= n_ovf;
            end
        end
    end

endmodule

[rtl/jnsc_obuf.sv]
// Result register with a one-entry skid stage towards the output channel.
module jnsc_obuf
    import jnsc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_res_valid,
    input  t_out_beat i_res,
    output logic      o_space,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out
);

    logic      r_out_valid;
    logic      r_skid_valid;
    t_out_beat r_out;
    t_out_beat r_skid;
    logic      w_drain;

    assign w_drain = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_drain) begin
            r_out_valid  <= r_skid_valid || i_res_valid;
            r_skid_valid <= 1'b0;
        end else if (i_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_drain) begin
            r_out <= r_skid_valid ? r_skid : i_res;
        end else if (i_res_valid) begin
            r_skid <= i_res;
        end
    end

    assign o_space     = !r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[rtl/json_nesting_shape_checker_top.sv]
// Top level of the JSON nesting shape checker.
//
// The input channel carries one document byte per beat, with last_byte set on
// the final byte. Every byte is scanned in the cycle it is accepted, so the
// block takes one byte per clock cycle for as long as it keeps ready high.
// Only the final byte of a document produces a result beat: doc_valid and
// depth_overflow are registered before they appear on the output channel,
// and the scanner state is already clear for the next document.
// The opener stack is a MAX_DEPTH-entry memory; its top entry and the entry
// beneath it are kept in registers so that a closer is checked at once.
// A result waiting on a stalled receiver sits in the result register while
// bytes keep flowing; a second result then goes into a skid stage, and input
// ready falls only while that skid stage is occupied.
// Reset is synchronous and active low; it empties the stack and the result
// path and clears all scanner flags. No clearing pass is needed.
`include "json_nesting_shape_checker_top_defines.svh"

module json_nesting_shape_checker_top
    import jnsc_pkg::*;
#(
    parameter int MAX_DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out
);

    logic      w_fire;
    logic      w_res_valid;
    t_out_beat w_res;
    t_stk_ctl  w_stk_ctl;
    t_stk_sts  w_stk_sts;

    assign w_fire = i_in_valid && o_in_ready;

    jnsc_stack #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_stk_ctl),
        .o_sts   (w_stk_sts)
    );

    jnsc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_in        (i_in),
        .i_sts       (w_stk_sts),
        .o_ctl       (w_stk_ctl),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    jnsc_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .o_space     (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    `JNSC_ASSERT_NOW(a_no_push_when_full, w_stk_ctl.push, !w_stk_sts.full, "Push into a full stack")
    `JNSC_ASSERT_NOW(a_overflow_invalid, o_out_valid && o_out.depth_overflow, !o_out.doc_valid, "Overflow reported as valid")
    `JNSC_ASSERT_NEXT(a_last_gives_result, w_fire && i_in.last_byte, o_out_valid, "Final byte gave no result")
    `JNSC_ASSERT_NOW(a_stall_has_result, !o_in_ready, o_out_valid, "Input stalled with no result pending")

endmodule

[verif/tb_json_nesting_shape_checker_top.sv]
// Self-checking testbench for the JSON nesting shape checker top level.
module tb_json_nesting_shape_checker_top;
    timeunit 1ns;
    timeprecision 1ps;
    import jnsc_pkg::*;

    localparam int MAX_DEPTH    = 64;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int DIR_ROWS     = 24;

    typedef enum int {
        DOC_WELL,
        DOC_BROKEN,
        DOC_NOISE,
        DOC_DEEP
    } t_doc_kind;

    typedef enum int {
        MUT_FLIP,
        MUT_CUT,
        MUT_SECOND_ROOT,
        MUT_INSERT,
        MUT_EXTRA_CLOSER
    } t_mutation;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       typed;
        t_out_beat  want;
    } t_dir_row;

    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{CH_LBRACE, 1'b0, 1'b0, 2'b00},
        '{CH_RBRACE, 1'b1, 1'b1, 2'b10},
        '{CH_QUOTE,  1'b0, 1'b0, 2'b00},
        '{CH_BSLASH, 1'b0, 1'b0, 2'b00},
        '{CH_QUOTE,  1'b0, 1'b0, 2'b00},
        '{CH_QUOTE,  1'b0, 1'b0, 2'b00},
        '{CH_LBRACE, 1'b0, 1'b0, 2'b00},
        '{CH_LBRACK, 1'b0, 1'b0, 2'b00},
        '{CH_RBRACK, 1'b0, 1'b0, 2'b00},
        '{CH_RBRACE, 1'b0, 1'b0, 2'b00},
        '{CH_CR,     1'b1, 1'b0, 2'b00},
        '{CH_LBRACK, 1'b1, 1'b1, 2'b00},
        '{CH_LBRACE, 1'b0, 1'b0, 2'b00},
        '{CH_RBRACK, 1'b0, 1'b0, 2'b00},
        '{CH_RBRACE, 1'b0, 1'b0, 2'b00},
        '{8'h00,     1'b0, 1'b0, 2'b00},
        '{8'hFF,     1'b1, 1'b1, 2'b00},
        '{CH_LBRACE, 1'b0, 1'b0, 2'b00},
        '{CH_RBRACE, 1'b0, 1'b0, 2'b00},
        '{CH_LBRACE, 1'b1, 1'b1, 2'b00},
        '{CH_LBRACE, 1'b0, 1'b0, 2'b00},
        '{CH_QUOTE,  1'b0, 1'b0, 2'b00},
        '{8'hFF,     1'b1, 1'b1, 2'b00},
        '{8'h00,     1'b1, 1'b1, 2'b00}
    };

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_beat  i_in        = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_beat o_out;

    logic [MAX_DEPTH-1:0] open_is_brace;
    int                   open_levels;
    bit                   quote_open;
    bit                   escape_next;
    bit                   root_taken;
    bit                   shape_bad;
    bit                   overflow_hit;

    t_out_beat  verdict_q [$];
    logic [7:0] doc_q [$];
    bit         row_typed = 1'b0;
    t_out_beat  row_want  = '0;
    int         mismatches = 0;
    int         cycle_count = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         hold_req = 0;

    json_nesting_shape_checker_top #(
        .MAX_DEPTH (MAX_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic want, input logic got);
        mismatches++;
        $display("[%0t] mismatch on %s: expected %0b, got %0b", $time, what, want, got);
    endtask

    task automatic clear_scan();
        open_is_brace = '0;
        open_levels   = 0;
        quote_open    = 1'b0;
        escape_next   = 1'b0;
        root_taken    = 1'b0;
        shape_bad     = 1'b0;
        overflow_hit  = 1'b0;
    endtask

    task automatic scan_byte(input t_in_beat b);
        logic [7:0] c;
        t_out_beat  verdict;
        c = b.byte_in;
        if (!shape_bad) begin
            if (quote_open) begin
                if (escape_next)
                    escape_next = 1'b0;
                else if (c == CH_BSLASH)
                    escape_next = 1'b1;
                else if (c == CH_QUOTE)
                    quote_open = 1'b0;
            end else if (c == CH_QUOTE) begin
                quote_open = 1'b1;
            end else if (c == CH_LBRACE || c == CH_LBRACK) begin
                if (open_levels == 0 && (root_taken || c != CH_LBRACE)) begin
                    shape_bad = 1'b1;
                end else begin
                    if (open_levels == 0)
                        root_taken = 1'b1;
                    if (open_levels >= MAX_DEPTH) begin
                        overflow_hit = 1'b1;
                        shape_bad    = 1'b1;
                    end else begin
                        open_is_brace[open_levels] = (c == CH_LBRACE);
                        open_levels++;
                    end
                end
            end else if (c == CH_RBRACE || c == CH_RBRACK) begin
                if (open_levels == 0 || open_is_brace[open_levels-1] != (c == CH_RBRACE))
                    shape_bad = 1'b1;
                else
                    open_levels--;
            end else if (open_levels == 0 && c != CH_SPACE && (c < CH_TAB || c > CH_CR)) begin
                shape_bad = 1'b1;
            end
        end
        if (b.last_byte) begin
            verdict.doc_valid      = !shape_bad && root_taken && !quote_open && open_levels == 0;
            verdict.depth_overflow = overflow_hit;
            verdict_q.insert(verdict_q.size(), row_typed ? row_want : verdict);
            clear_scan();
        end
    endtask

    task automatic check_verdict(input t_out_beat got);
        t_out_beat want;
        if (verdict_q.size() == 0) begin
            report_mismatch("result beat with none pending", 1'b0, 1'b1);
        end else begin
            want = verdict_q.pop_front();
            if (got.doc_valid !== want.doc_valid)
                report_mismatch("doc_valid", want.doc_valid, got.doc_valid);
            if (got.depth_overflow !== want.depth_overflow)
                report_mismatch("depth_overflow", want.depth_overflow, got.depth_overflow);
        end
    endtask

    initial clear_scan();

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                check_verdict(o_out);
            if (i_in_valid && o_in_ready)
                scan_byte(i_in);
        end
    end

    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready = 1'b0;
            end else begin
                i_out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    task automatic put_beat(input t_in_beat b, input bit typed, input t_out_beat want);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in       = b;
        row_typed  = typed;
        row_want   = want;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_doc();
        for (int i = 0; i < doc_q.size(); i++)
            put_beat('{byte_in: doc_q[i], last_byte: (i == doc_q.size() - 1)}, 1'b0, '0);
    endtask

    task automatic add_byte(input logic [7:0] c);
        doc_q.insert(doc_q.size(), c);
    endtask

    task automatic add_string();
        logic [7:0] c;
        add_byte(CH_QUOTE);
        repeat ($urandom_range(0, 5)) begin
            if ($urandom_range(0, 4) == 0) begin
                add_byte(CH_BSLASH);
                add_byte(8'($urandom_range(0, 255)));
            end else begin
                c = 8'($urandom_range(0, 255));
                if (c == CH_QUOTE || c == CH_BSLASH)
                    c = CH_LBRACE;
                add_byte(c);
            end
        end
        add_byte(CH_QUOTE);
    endtask

    task automatic add_pad();
        int pick;
        repeat ($urandom_range(0, 2)) begin
            pick = $urandom_range(0, 7);
            if (pick > 5)
                add_string();
            else
                add_byte((pick == 5) ? CH_SPACE : CH_TAB + 8'(pick));
        end
    endtask

    task automatic add_object(input int opens_first, input int max_nest, input int steps);
        bit         kinds [$];
        bit         k;
        logic [7:0] c;
        add_byte(CH_LBRACE);
        kinds.insert(kinds.size(), 1'b1);
        repeat (opens_first) begin
            k = 1'($urandom_range(0, 1));
            add_byte(k ? CH_LBRACE : CH_LBRACK);
            kinds.insert(kinds.size(), k);
        end
        repeat (steps) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    if (kinds.size() < max_nest) begin
                        k = 1'($urandom_range(0, 1));
                        add_byte(k ? CH_LBRACE : CH_LBRACK);
                        kinds.insert(kinds.size(), k);
                    end
                end
                3, 4: begin
                    if (kinds.size() > 1) begin
                        k = kinds[kinds.size() - 1];
                        kinds.delete(kinds.size() - 1);
                        add_byte(k ? CH_RBRACE : CH_RBRACK);
                    end
                end
                5, 6: begin
                    add_string();
                end
                default: begin
                    do c = 8'($urandom_range(0, 255));
                    while (c == CH_LBRACE || c == CH_LBRACK || c == CH_RBRACE ||
                           c == CH_RBRACK || c == CH_QUOTE);
                    add_byte(c);
                end
            endcase
        end
        while (kinds.size() > 0) begin
            k = kinds[kinds.size() - 1];
            kinds.delete(kinds.size() - 1);
            add_byte(k ? CH_RBRACE : CH_RBRACK);
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        int        sent_bytes;
        int        sent_docs;
        int        pick;
        t_doc_kind kind;
        sent_bytes     = 0;
        sent_docs      = 0;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (sent_bytes < 20 || sent_docs < 2) begin
            pick = $urandom_range(0, 99);
            kind = t_doc_kind'((pick < 58) ? DOC_WELL : (pick < 83) ? DOC_BROKEN :
                               (pick < 96) ? DOC_NOISE : DOC_DEEP);
            doc_q.delete();
            case (kind)
                DOC_NOISE: begin
                    repeat ($urandom_range(1, 8))
                        add_byte(8'($urandom_range(0, 255)));
                end
                DOC_DEEP: begin
                    add_pad();
                    add_object($urandom_range(MAX_DEPTH - 3, MAX_DEPTH + 2), MAX_DEPTH + 4,
                               $urandom_range(0, 4));
                    add_pad();
                end
                default: begin
                    add_pad();
                    add_object(0, $urandom_range(1, 8), $urandom_range(0, 14));
                    add_pad();
                    if (kind == DOC_BROKEN) begin
                        pick = $urandom_range(0, doc_q.size() - 1);
                        case (t_mutation'($urandom_range(0, 4)))
                            MUT_FLIP:        doc_q[pick] = 8'($urandom_range(0, 255));
                            MUT_CUT:         repeat ($urandom_range(1, doc_q.size() - 1))
                                                 doc_q.delete(doc_q.size() - 1);
                            MUT_SECOND_ROOT: begin
                                add_byte($urandom_range(0, 1) ? CH_LBRACE : CH_LBRACK);
                                add_byte(CH_RBRACE);
                            end
                            MUT_INSERT:      doc_q.insert(pick, 8'($urandom_range(0, 255)));
                            MUT_EXTRA_CLOSER: begin
                                doc_q.insert(pick, $urandom_range(0, 1) ? CH_RBRACE : CH_RBRACK);
                            end
                            default: ;
                        endcase
                    end
                end
            endcase
            sent_bytes += doc_q.size();
            sent_docs++;
            send_doc();
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            put_beat('{byte_in: DIR_TABLE[i].ch, last_byte: DIR_TABLE[i].last},
                     DIR_TABLE[i].typed, DIR_TABLE[i].want);

        // Nesting exactly at the stack capacity, then one level beyond it.
        doc_q.delete();
        add_object(MAX_DEPTH - 1, 0, 0);
        send_doc();
        doc_q.delete();
        add_object(MAX_DEPTH, 0, 0);
        send_doc();

        run_phase(0, 0);
        run_phase(51, 0);
        run_phase(0, 51);
        run_phase(31, 31);

        // The receiver holds off while short documents keep coming, so that
        // results pile up and the input side has to stall.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 80;
        repeat (10) begin
            doc_q.delete();
            add_byte(CH_LBRACE);
            add_byte(CH_RBRACE);
            send_doc();
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
